@@ design/distance_vector_route_update_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the distance-vector route engine
// Implication and next-cycle implication checks, clocked, with reset gating.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH

// same-cycle implication
`define DVRU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DVRU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dvru_pkg.sv @@
// ----------------------------------------------------------------------------
// dvru_pkg
// Shared constants, FSM states and memory request type for the route engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dvru_pkg;

    localparam int NODES     = 16;
    localparam int NODE_W    = $clog2(NODES);
    localparam int HOP_W     = $clog2(NODES + 1);
    localparam int COST_W    = 8;
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int MEM_DEPTH = NODES * NODES;

    localparam logic [COST_W-1:0] COST_INF  = COST_W'(255);
    localparam logic [HOP_W-1:0]  NO_HOP    = HOP_W'(NODES);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    // request kinds
    localparam logic REQ_LINK   = 1'b0;
    localparam logic REQ_VECTOR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LC_RD,
        ST_LC_CMP,
        ST_RC_START,
        ST_RC_SCAN,
        ST_RC_OWN,
        ST_RC_WB,
        ST_EM_RD,
        ST_EM_OUT
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [COST_W-1:0] wr_data;
    } t_mem_req;

endpackage

`default_nettype wire

@@ design/dvru_cost_mem.sv @@
// ----------------------------------------------------------------------------
// dvru_cost_mem
// Cost matrix: one write, one registered read; unwritten entries read as reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_cost_mem import dvru_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mem_req          i_req,
    output logic [COST_W-1:0]      o_rd_data
);

    logic [COST_W-1:0]    r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid;
    logic [COST_W-1:0]    r_rd_data;
    logic                 r_rd_valid;
    logic                 r_rd_diag;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[i_req.rd_addr];
            r_rd_valid <= r_valid[i_req.rd_addr];
            r_rd_diag  <= (i_req.rd_addr[ADDR_W-1:NODE_W] == i_req.rd_addr[NODE_W-1:0]);
        end
    end

    // per-entry written flags stand in for the reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : (r_rd_diag ? '0 : COST_INF);

endmodule

`default_nettype wire

@@ design/dvru_engine.sv @@
// ----------------------------------------------------------------------------
// dvru_engine
// Request sequencer: link/hop tables, Bellman-Ford scan, row emission.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_engine import dvru_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [NODE_W-1:0] i_self,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_req_type,
    input  wire logic [NODE_W-1:0] i_peer_node,
    input  wire logic [NODE_W-1:0] i_vector_dest,
    input  wire logic [COST_W-1:0] i_cost_value,
    input  wire logic              i_last_element,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [NODE_W-1:0]      o_route_dest,
    output logic [HOP_W-1:0]       o_next_hop,
    output logic [COST_W-1:0]      o_route_cost,
    output logic                   o_route_update,
    output logic                   o_send_row,
    output logic                   o_last_entry,
    output t_mem_req               o_mem_req,
    input  wire logic [COST_W-1:0] i_rd_data
);

    t_state r_state, n_state;

    logic              r_type, n_type;
    logic [NODE_W-1:0] r_peer, n_peer;
    logic [COST_W-1:0] r_cost, n_cost;
    logic [NODE_W-1:0] r_j, n_j;
    logic [NODE_W-1:0] r_k, n_k;
    logic [NODE_W-1:0] r_pk, n_pk;
    logic              r_pv, n_pv;
    logic [COST_W-1:0] r_best, n_best;
    logic [HOP_W-1:0]  r_hop, n_hop;
    logic              r_changed, n_changed;
    logic              r_upd_all, n_upd_all;

    logic [COST_W-1:0] r_link    [NODES];
    logic [HOP_W-1:0]  r_hop_tab [NODES];

    logic              r_out_valid, n_out_valid;
    logic [NODE_W-1:0] r_out_dest, n_out_dest;
    logic [HOP_W-1:0]  r_out_hop, n_out_hop;
    logic [COST_W-1:0] r_out_cost, n_out_cost;
    logic              r_out_upd, n_out_upd;
    logic              r_out_send, n_out_send;
    logic              r_out_last, n_out_last;

    logic              link_we;
    logic [NODE_W-1:0] link_waddr;
    logic [COST_W-1:0] link_wdata;
    logic              hop_we;
    logic [NODE_W-1:0] hop_waddr;
    logic [HOP_W-1:0]  hop_wdata;

    logic              in_take;
    logic              out_free;
    logic [COST_W-1:0] cost_in;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] lc;
    logic              better;
    logic              any_nb;
    logic              own;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_take    = i_in_valid & o_in_ready;
    assign out_free   = ~r_out_valid | i_out_ready;
    assign cost_in    = (i_cost_value >= COST_INF) ? COST_INF : i_cost_value;

    // relaxation of the candidate read in the previous cycle
    assign lc     = r_link[r_pk];
    assign sum    = {1'b0, lc} + {1'b0, i_rd_data};
    assign better = r_pv && (lc != '0) && (sum < {1'b0, r_best});
    assign own    = (r_j == i_self);

    always_comb begin
        any_nb = 1'b0;
        for (int y = 0; y < NODES; y++) begin
            if ((NODE_W'(y) != i_self) && (r_link[y] != COST_INF)) begin
                any_nb = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_type      = r_type;
        n_peer      = r_peer;
        n_cost      = r_cost;
        n_j         = r_j;
        n_k         = r_k;
        n_pk        = r_k;
        n_pv        = (r_state == ST_RC_SCAN);
        n_best      = r_best;
        n_hop       = r_hop;
        n_changed   = r_changed;
        n_upd_all   = r_upd_all;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out_dest  = r_out_dest;
        n_out_hop   = r_out_hop;
        n_out_cost  = r_out_cost;
        n_out_upd   = r_out_upd;
        n_out_send  = r_out_send;
        n_out_last  = r_out_last;
        o_mem_req   = '0;
        link_we     = 1'b0;
        link_waddr  = i_peer_node;
        link_wdata  = cost_in;
        hop_we      = 1'b0;
        hop_waddr   = i_peer_node;
        hop_wdata   = (cost_in >= COST_INF) ? NO_HOP : HOP_W'(i_peer_node);

        if (better) begin
            n_best = sum[COST_W-1:0];
            n_hop  = HOP_W'(r_pk);
        end

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_type = i_req_type;
                    n_peer = i_peer_node;
                    n_cost = cost_in;
                    case (i_req_type)
                        REQ_LINK: begin
                            if (i_peer_node != i_self) begin
                                link_we = 1'b1;
                                hop_we  = 1'b1;
                                n_state = ST_LC_RD;
                            end
                        end
                        REQ_VECTOR: begin
                            if (i_peer_node != i_self) begin
                                o_mem_req.wr_en   = 1'b1;
                                o_mem_req.wr_addr = {i_peer_node, i_vector_dest};
                                o_mem_req.wr_data = cost_in;
                            end
                            if (i_last_element) begin
                                n_j       = '0;
                                n_changed = 1'b0;
                                n_upd_all = 1'b1;
                                n_state   = ST_RC_START;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LC_RD: begin
                o_mem_req.rd_en   = 1'b1;
                o_mem_req.rd_addr = {i_self, r_peer};
                n_state           = ST_LC_CMP;
            end
            ST_LC_CMP: begin
                n_j = '0;
                if (r_cost <= i_rd_data) begin
                    o_mem_req.wr_en   = 1'b1;
                    o_mem_req.wr_addr = {i_self, r_peer};
                    o_mem_req.wr_data = r_cost;
                    n_upd_all         = 1'b0;
                    n_state           = ST_EM_RD;
                end else begin
                    n_upd_all = 1'b1;
                    n_changed = 1'b0;
                    n_state   = ST_RC_START;
                end
            end
            ST_RC_START: begin
                if (own) begin
                    if (r_j == LAST_NODE) begin
                        n_j     = '0;
                        n_state = ST_EM_RD;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_k     = '0;
                    n_best  = COST_INF;
                    n_hop   = NO_HOP;
                    n_state = ST_RC_SCAN;
                end
            end
            ST_RC_SCAN: begin
                o_mem_req.rd_en   = 1'b1;
                o_mem_req.rd_addr = {r_k, r_j};
                n_k               = r_k + 1'b1;
                if (r_k == LAST_NODE) begin
                    n_state = ST_RC_OWN;
                end
            end
            ST_RC_OWN: begin
                o_mem_req.rd_en   = 1'b1;
                o_mem_req.rd_addr = {i_self, r_j};
                n_state           = ST_RC_WB;
            end
            ST_RC_WB: begin
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_addr = {i_self, r_j};
                o_mem_req.wr_data = r_best;
                hop_we            = 1'b1;
                hop_waddr         = r_j;
                hop_wdata         = r_hop;
                if (i_rd_data != r_best) begin
                    n_changed = 1'b1;
                end
                if (r_j == LAST_NODE) begin
                    n_j     = '0;
                    n_state = ST_EM_RD;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_RC_START;
                end
            end
            ST_EM_RD: begin
                o_mem_req.rd_en   = 1'b1;
                o_mem_req.rd_addr = {i_self, r_j};
                n_state           = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_dest  = r_j;
                    n_out_hop   = own ? HOP_W'(i_self) : r_hop_tab[r_j];
                    n_out_cost  = own ? '0 : i_rd_data;
                    n_out_upd   = !own && (r_upd_all || (r_j == r_peer));
                    n_out_send  = any_nb && ((r_type == REQ_LINK) || r_changed);
                    n_out_last  = (r_j == LAST_NODE);
                    if (r_j == LAST_NODE) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = ST_EM_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_type     <= n_type;
        r_peer     <= n_peer;
        r_cost     <= n_cost;
        r_j        <= n_j;
        r_k        <= n_k;
        r_pk       <= n_pk;
        r_best     <= n_best;
        r_hop      <= n_hop;
        r_changed  <= n_changed;
        r_upd_all  <= n_upd_all;
        r_out_dest <= n_out_dest;
        r_out_hop  <= n_out_hop;
        r_out_cost <= n_out_cost;
        r_out_upd  <= n_out_upd;
        r_out_send <= n_out_send;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    // link table resets with entry 0 as the own node; next hops to none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                r_link[i]    <= (i == 0) ? '0 : COST_INF;
                r_hop_tab[i] <= NO_HOP;
            end
        end else begin
            if (link_we) begin
                r_link[link_waddr] <= link_wdata;
            end
            if (hop_we) begin
                r_hop_tab[hop_waddr] <= hop_wdata;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_route_dest   = r_out_dest;
    assign o_next_hop     = r_out_hop;
    assign o_route_cost   = r_out_cost;
    assign o_route_update = r_out_upd;
    assign o_send_row     = r_out_send;
    assign o_last_entry   = r_out_last;

endmodule

`default_nettype wire

@@ design/distance_vector_route_update.sv @@
// ----------------------------------------------------------------------------
// distance_vector_route_update: Bellman-Ford route engine for one node
// Vector element, not last: written straight to the matrix. Direct link change:
// time set by own-row emission off the cost memory's single read port.
// Recompute, per destination: 16 matrix reads, then the own read and the write.
// Synchronous active-low reset; cost memory reads as reset contents at once.
// ----------------------------------------------------------------------------
`default_nettype none

// A full recompute (last vector element, or a link getting worse) scans every
// destination but the own one and is followed by the 16-entry row. All cost
// traffic goes through one read and one write port of the cost memory, which
// sets the pace of both.
//
// Reset: self index 0, link costs infinity except entry 0 (zero), next hops
// none. The 256-entry matrix has a written flag per entry cleared at reset,
// so no clearing pass is needed: unwritten entries read as 0 on the
// diagonal and infinity elsewhere.
//
// The self index register sits at byte address 0 of the APB space and may
// only be changed while no request is in flight.

module distance_vector_route_update import dvru_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // request channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_req_type,
    input  wire logic [NODE_W-1:0] i_peer_node,
    input  wire logic [NODE_W-1:0] i_vector_dest,
    input  wire logic [COST_W-1:0] i_cost_value,
    input  wire logic              i_last_element,
    // route row channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [NODE_W-1:0]      o_route_dest,
    output logic [HOP_W-1:0]       o_next_hop,
    output logic [COST_W-1:0]      o_route_cost,
    output logic                   o_route_update,
    output logic                   o_send_row,
    output logic                   o_last_entry
);

    // register index, taken from the word address bit
    localparam logic REG_SELF = 1'b0;

    logic [NODE_W-1:0] r_self;
    t_mem_req          mem_req;
    logic [COST_W-1:0] mem_rd_data;
    logic              reg_hit;

    assign reg_hit = (paddr[2] == REG_SELF);
    assign pready  = 1'b1;

    // zero-wait APB: write lands on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self <= '0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_self <= pwdata[NODE_W-1:0];
        end
    end

    assign prdata = reg_hit ? 32'(r_self) : '0;

    // sequencer: tables, scan and row emission
    dvru_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_self         (r_self),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_peer_node    (i_peer_node),
        .i_vector_dest  (i_vector_dest),
        .i_cost_value   (i_cost_value),
        .i_last_element (i_last_element),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_route_dest   (o_route_dest),
        .o_next_hop     (o_next_hop),
        .o_route_cost   (o_route_cost),
        .o_route_update (o_route_update),
        .o_send_row     (o_send_row),
        .o_last_entry   (o_last_entry),
        .o_mem_req      (mem_req),
        .i_rd_data      (mem_rd_data)
    );

    // cost matrix, row = advertising node, column = destination
    dvru_cost_mem u_cost_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

@@ design/dvru_checker.sv @@
// ----------------------------------------------------------------------------
// dvru_checker
// Port-level checks on route row emission, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "distance_vector_route_update_assert.svh"

module dvru_checker import dvru_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic [NODE_W-1:0] o_route_dest,
    input wire logic              o_last_entry
);

    `DVRU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "row entry dropped while stalled")
    `DVRU_ASSERT_IMP(a_last_dest, i_clk, i_rst_n, o_out_valid && o_last_entry, o_route_dest == LAST_NODE, "last entry not on final destination")
    `DVRU_ASSERT_IMP(a_row_busy, i_clk, i_rst_n, o_out_valid && !o_last_entry, !o_in_ready, "request taken in the middle of a row")
    `DVRU_ASSERT_NXT(a_row_order, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last_entry, !o_out_valid || (o_route_dest == $past(o_route_dest) + 1'b1), "row entries out of order")

endmodule

bind distance_vector_route_update dvru_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_route_dest (o_route_dest),
    .o_last_entry (o_last_entry)
);

`default_nettype wire

@@ bench/dvru_row_checker.sv @@
// ----------------------------------------------------------------------------
// Route row checker
// Follows self-index writes and accepted requests, keeps its own copy of the
// cost matrix, link costs and next hops, and compares every emitted row entry
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module dvru_row_checker import dvru_pkg::*; #(
    parameter logic [2:0] SELF_NODE_ADDR = '0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              i_in_valid,
    input  logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [NODE_W-1:0] i_peer_node,
    input  logic [NODE_W-1:0] i_vector_dest,
    input  logic [COST_W-1:0] i_cost_value,
    input  logic              i_last_element,
    input  logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic [NODE_W-1:0] o_route_dest,
    input  logic [HOP_W-1:0]  o_next_hop,
    input  logic [COST_W-1:0] o_route_cost,
    input  logic              o_route_update,
    input  logic              o_send_row,
    input  logic              o_last_entry,
    output int                mismatch_count,
    output int                routes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [NODE_W-1:0] dest;
        logic [HOP_W-1:0]  hop;
        logic [COST_W-1:0] cost;
        logic              upd;
        logic              send;
        logic              last;
    } t_route_entry;

    logic [COST_W-1:0] est       [NODES][NODES];
    logic [COST_W-1:0] link_cost [NODES];
    logic [HOP_W-1:0]  via       [NODES];
    logic [NODE_W-1:0] self_id;
    t_route_entry      route_q[$];

    function automatic void clear_tables();
        for (int r = 0; r < NODES; r++) begin
            for (int c = 0; c < NODES; c++) begin
                est[r][c] = (r == c) ? '0 : COST_INF;
            end
            link_cost[r] = COST_INF;
            via[r]       = NO_HOP;
        end
        link_cost[0] = '0;
        self_id      = '0;
    endfunction

    // Bellman-Ford pass over own row; a zero link cost means not a neighbour
    function automatic bit relax_routes();
        bit changed;
        int best;
        int pick;
        int sum;
        changed = 1'b0;
        for (int j = 0; j < NODES; j++) begin
            if (j == self_id) continue;
            best = COST_INF;
            pick = NODES;
            for (int k = 0; k < NODES; k++) begin
                if (link_cost[k] == '0) continue;
                sum = int'(link_cost[k]) + int'(est[k][j]);
                if (sum < best) begin
                    best = sum;
                    pick = k;
                end
            end
            if (est[self_id][j] != COST_W'(best)) changed = 1'b1;
            est[self_id][j] = COST_W'(best);
            via[j]          = HOP_W'(pick);
        end
        return changed;
    endfunction

    function automatic bit has_neighbour();
        for (int y = 0; y < NODES; y++) begin
            if (y != self_id && link_cost[y] != COST_INF) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void queue_row(bit upd_all, logic [NODE_W-1:0] upd_one, bit send);
        t_route_entry e;
        for (int j = 0; j < NODES; j++) begin
            e.dest = NODE_W'(j);
            e.hop  = (j == self_id) ? HOP_W'(self_id) : via[j];
            e.cost = (j == self_id) ? '0 : est[self_id][j];
            e.upd  = (j != self_id) && (upd_all || j == upd_one);
            e.send = send;
            e.last = (j == NODES - 1);
            route_q.push_back(e);
        end
    endfunction

    function automatic void take_request(logic kind, logic [NODE_W-1:0] peer,
                                         logic [NODE_W-1:0] dest, logic [COST_W-1:0] cost,
                                         logic last);
        bit changed;
        if (kind == REQ_LINK) begin
            if (peer == self_id) return;
            link_cost[peer] = cost;
            via[peer]       = (cost >= COST_INF) ? NO_HOP : HOP_W'(peer);
            if (cost <= est[self_id][peer]) begin
                est[self_id][peer] = cost;
                queue_row(1'b0, peer, has_neighbour());
            end else begin
                void'(relax_routes());
                queue_row(1'b1, peer, has_neighbour());
            end
        end else begin
            if (peer != self_id) est[peer][dest] = cost;
            if (last) begin
                changed = relax_routes();
                queue_row(1'b1, peer, changed && has_neighbour());
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_route_entry seen;
        t_route_entry want;
        if (!i_rst_n) begin
            clear_tables();
            route_q.delete();
            mismatch_count = 0;
            routes_pending <= 0;
        end else begin
            // rows leaving before this edge's request can add any
            if (o_out_valid && i_out_ready) begin
                seen = {o_route_dest, o_next_hop, o_route_cost,
                        o_route_update, o_send_row, o_last_entry};
                if (route_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected route entry dest %0d hop %0d cost %0d",
                             $time, seen.dest, seen.hop, seen.cost);
                end else begin
                    want = route_q.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        $write("%0t: route entry mismatch: expected dest %0d hop %0d ",
                               $time, want.dest, want.hop);
                        $write("cost %0d upd %0b send %0b last %0b, ",
                               want.cost, want.upd, want.send, want.last);
                        $display("got dest %0d hop %0d cost %0d upd %0b send %0b last %0b",
                                 seen.dest, seen.hop, seen.cost, seen.upd, seen.send,
                                 seen.last);
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == SELF_NODE_ADDR)
                self_id = pwdata[NODE_W-1:0];
            if (i_in_valid && o_in_ready)
                take_request(i_req_type, i_peer_node, i_vector_dest, i_cost_value,
                             i_last_element);
            routes_pending <= route_q.size();
        end
    end

endmodule

@@ bench/tb_distance_vector_route_update.sv @@
// ----------------------------------------------------------------------------
// Distance-vector route engine testbench
// Drives link-change and neighbour-vector requests with random gaps and row
// back-pressure, moves the self index through several values between phases,
// and leaves all row checking to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_distance_vector_route_update import dvru_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] SELF_NODE_ADDR = 3'd0;  // self index register, byte 0
    localparam int         MAX_GAP        = 12;
    // settle well past a full recompute plus its row
    localparam int         SETTLE_CYCLES  = 400;
    // longest correct silence is one recompute plus both gaps; allow lots more
    localparam int         QUIET_LIMIT    = 4000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_req_type;
    logic [NODE_W-1:0] i_peer_node;
    logic [NODE_W-1:0] i_vector_dest;
    logic [COST_W-1:0] i_cost_value;
    logic              i_last_element;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [NODE_W-1:0] o_route_dest;
    logic [HOP_W-1:0]  o_next_hop;
    logic [COST_W-1:0] o_route_cost;
    logic              o_route_update;
    logic              o_send_row;
    logic              o_last_entry;

    int                mismatch_count;
    int                routes_pending;
    int                quiet_cycles;
    int                requests_sent;
    bit                steady_run;     // both sides run without gaps while set
    logic [NODE_W-1:0] current_self;

    distance_vector_route_update DUT (.*);

    dvru_row_checker #(.SELF_NODE_ADDR(SELF_NODE_ADDR)) row_check (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Watchdog: any handshake or APB access counts as progress
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int pick_gap();
        return steady_run ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Costs lean small so that routes chain up; zero, infinity and one below
    // infinity turn up often as they sit on the saturation edge.
    function automatic logic [COST_W-1:0] rand_cost();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COST_INF;
            2:       return COST_INF - 1'b1;
            3:       return COST_W'($urandom);
            default: return COST_W'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [NODE_W-1:0] rand_peer();
        return ($urandom_range(0, 7) == 0) ? current_self : NODE_W'($urandom_range(0, NODES - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Valid stays up across back-to-back requests so that it
    // never sees two assignments in one step.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic kind, input logic [NODE_W-1:0] peer,
                                input logic [NODE_W-1:0] dest,
                                input logic [COST_W-1:0] cost, input logic last);
        int gap;
        if ($urandom_range(0, 39) == 0) steady_run = !steady_run;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_type     <= kind;
        i_peer_node    <= peer;
        i_vector_dest  <= dest;
        i_cost_value   <= cost;
        i_last_element <= last;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        requests_sent++;
    endtask

    // One neighbour vector: in order or shuffled, whole or cut short, closed
    // by a last element or left open.
    task automatic send_vector(input logic [NODE_W-1:0] peer, input int count,
                               input bit shuffled, input bit closed);
        logic [NODE_W-1:0] dests [NODES];
        logic [NODE_W-1:0] tmp;
        int                j;
        for (int i = 0; i < NODES; i++) dests[i] = NODE_W'(i);
        if (shuffled) begin
            for (int i = NODES - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = dests[i];
                dests[i] = dests[j];
                dests[j] = tmp;
            end
        end
        for (int i = 0; i < count; i++)
            send_request(REQ_VECTOR, peer, dests[i], rand_cost(), closed && i == count - 1);
    endtask

    // Drop valid, wait for every predicted row, then let any row-less request
    // finish inside the engine.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (routes_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_self(input logic [NODE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SELF_NODE_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        current_self = value;
    endtask

    // Mostly whole vectors, then link changes with junk in the unused fields,
    // and a share of broken vectors.
    task automatic random_traffic(input int target);
        int pick;
        while (requests_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                send_vector(rand_peer(), NODES, $urandom_range(0, 3) == 0, 1'b1);
            else if (pick < 9)
                send_request(REQ_LINK, rand_peer(), NODE_W'($urandom), rand_cost(),
                             1'($urandom_range(0, 1)));
            else
                send_vector(rand_peer(), $urandom_range(1, NODES), 1'b1,
                            1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Row side: random stalls on ready, with the same gap-free stretches
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        i_in_valid     <= 1'b0;
        i_req_type     <= REQ_LINK;
        i_peer_node    <= '0;
        i_vector_dest  <= '0;
        i_cost_value   <= '0;
        i_last_element <= 1'b0;
        steady_run     = 1'b0;
        requests_sent  = 0;
        current_self   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_self('0);

        // link change naming self: dropped, no row
        send_request(REQ_LINK, '0, '0, COST_W'(5), 1'b0);
        // infinite link first, while no neighbour exists: row with send clear
        send_request(REQ_LINK, NODE_W'(2), '0, COST_INF, 1'b0);
        // direct improvements
        send_request(REQ_LINK, NODE_W'(1), '0, COST_W'(3), 1'b0);
        send_request(REQ_LINK, LAST_NODE, '0, COST_INF - 1'b1, 1'b0);
        // vector from node 1, closed by its last element
        send_request(REQ_VECTOR, NODE_W'(1), '0, COST_W'(1), 1'b0);
        send_request(REQ_VECTOR, NODE_W'(1), NODE_W'(5), COST_W'(2), 1'b0);
        send_request(REQ_VECTOR, NODE_W'(1), LAST_NODE, '0, 1'b0);
        send_request(REQ_VECTOR, NODE_W'(1), NODE_W'(3), COST_INF, 1'b0);
        send_request(REQ_VECTOR, NODE_W'(1), NODE_W'(1), '0, 1'b1);
        // sums through an almost-infinite link saturate
        send_request(REQ_VECTOR, LAST_NODE, LAST_NODE, COST_INF, 1'b1);
        // element from self: write dropped, recompute still runs, nothing changes
        send_request(REQ_VECTOR, '0, NODE_W'(4), COST_W'(1), 1'b1);
        // link getting worse forces a full recompute
        send_request(REQ_LINK, NODE_W'(1), '0, COST_W'(200), 1'b0);
        // zero link: taken directly, then the node drops out of the minimum
        send_request(REQ_LINK, LAST_NODE, '0, '0, 1'b0);
        send_request(REQ_VECTOR, NODE_W'(1), NODE_W'(7), COST_INF - 1'b1, 1'b1);
        // link lost altogether
        send_request(REQ_LINK, NODE_W'(1), '0, COST_INF, 1'b0);
        send_request(REQ_LINK, NODE_W'(3), '0, COST_W'(1), 1'b0);
        send_request(REQ_VECTOR, NODE_W'(3), NODE_W'(10), '0, 1'b1);
        send_request(REQ_LINK, LAST_NODE, '0, COST_INF, 1'b0);
        drain();

        // random phases under different self indexes, extremes included
        write_self(LAST_NODE);
        random_traffic(requests_sent + 135);
        drain();
        write_self(NODE_W'($urandom_range(1, NODES - 2)));
        random_traffic(requests_sent + 135);
        drain();
        write_self('0);
        random_traffic(requests_sent + 130);
        drain();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
